// ===== design/flow_dynamic_timeout_update_unit_assert.svh =====
// ----------------------------------------------------------------------------
// flow dynamic timeout update unit - assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef FLOW_DYNAMIC_TIMEOUT_UPDATE_UNIT_ASSERT_SVH
`define FLOW_DYNAMIC_TIMEOUT_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define FDTU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FDTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fdtu_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtu_pkg
// types, constants and lookup helpers of the flow dynamic timeout update unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdtu_pkg;

   localparam int SLOT_W      = 10;
   localparam int STAMP_W     = 40;
   localparam int COUNT_W     = 32;
   localparam int IDX_W       = 3;
   localparam int EXPIRE_W    = 41;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int FLOW_SLOTS_DEF = 1024;
   localparam int MBET_STEPS_DEF = 5;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [7:0]  SHORT_PACKETS_RST = 8'd5;
   localparam logic [23:0] SHORT_GAP_RST     = 24'd15000;
   localparam logic [23:0] LONG_TIMEOUT_RST  = 24'd64000;
   localparam logic [39:0] MARKS_RST         = 40'd38857019925;
   localparam logic [63:0] TIMEOUTS_A_RST    = 64'd2251868535259200000;
   localparam logic [15:0] TIMEOUT_E_RST     = 16'd4000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHORT_PACKETS = 3'd0,
      CSR_SHORT_GAP     = 3'd1,
      CSR_LONG_TIMEOUT  = 3'd2,
      CSR_MBET_MARKS    = 3'd3,
      CSR_TIMEOUTS_A    = 3'd4,
      CSR_TIMEOUT_E     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  flow_slot;
      logic [STAMP_W-1:0] stamp_ms;
      logic [7:0]         protocol;
      logic [COUNT_W-1:0] packet_count;
      logic               first_packet;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_out;
      logic [EXPIRE_W-1:0] expire_ms;
      logic                expire_now;
      logic                updated;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  short_packets;
      logic [23:0] short_gap;
      logic [23:0] long_timeout;
      logic [39:0] mbet_packet_marks;
      logic [63:0] mbet_timeouts_a;
      logic [15:0] mbet_timeout_e;
   } cfg_type;

   typedef struct packed {
      logic [STAMP_W-1:0] flow_start;
      logic [STAMP_W-1:0] prev_packet_time;
      logic [IDX_W-1:0]   mark_index;
      logic [IDX_W-1:0]   ladder_index;
   } flow_rec_type;

   function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] i,
                                                  input logic [IDX_W-1:0] last);
      return (i > last) ? last : i;
   endfunction

   function automatic logic [7:0] mark_at(input logic [39:0]      marks,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [IDX_W-1:0] last);
      logic [IDX_W-1:0] i;
      logic [7:0]       v;
      i = clamp_idx(idx, last);
      case (i)
         3'd0:    v = marks[7:0];
         3'd1:    v = marks[15:8];
         3'd2:    v = marks[23:16];
         3'd3:    v = marks[31:24];
         default: v = marks[39:32];
      endcase
      return v;
   endfunction

   function automatic logic [15:0] ladder_at(input logic [63:0]      tmo_a,
                                             input logic [15:0]      tmo_e,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [IDX_W-1:0] last);
      logic [IDX_W-1:0] i;
      logic [15:0]      v;
      i = clamp_idx(idx, last);
      case (i)
         3'd0:    v = tmo_a[15:0];
         3'd1:    v = tmo_a[31:16];
         3'd2:    v = tmo_a[47:32];
         3'd3:    v = tmo_a[63:48];
         default: v = tmo_e;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== design/fdtu_state_mem.sv =====
// ----------------------------------------------------------------------------
// fdtu_state_mem
// per-flow state memory, one write port and one read port, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdtu_state_mem
   import fdtu_pkg::*;
#(
   parameter int FLOW_SLOTS = FLOW_SLOTS_DEF,
   localparam int AW = $clog2(FLOW_SLOTS)
) (
   input  wire logic         clock,
   input  wire logic         rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output flow_rec_type      rd_data,
   input  wire logic         wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  flow_rec_type      wr_data
);

   flow_rec_type ram_ff [FLOW_SLOTS];
   flow_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/fdtu_csr.sv =====
// ----------------------------------------------------------------------------
// fdtu_csr
// configuration registers with their reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdtu_csr
   import fdtu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SHORT_PACKETS: cfg_in.short_packets     = csr_wdata[7:0];
            CSR_SHORT_GAP:     cfg_in.short_gap         = csr_wdata[23:0];
            CSR_LONG_TIMEOUT:  cfg_in.long_timeout      = csr_wdata[23:0];
            CSR_MBET_MARKS:    cfg_in.mbet_packet_marks = csr_wdata[39:0];
            CSR_TIMEOUTS_A:    cfg_in.mbet_timeouts_a   = csr_wdata;
            CSR_TIMEOUT_E:     cfg_in.mbet_timeout_e    = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_packets     <= SHORT_PACKETS_RST;
         cfg_ff.short_gap         <= SHORT_GAP_RST;
         cfg_ff.long_timeout      <= LONG_TIMEOUT_RST;
         cfg_ff.mbet_packet_marks <= MARKS_RST;
         cfg_ff.mbet_timeouts_a   <= TIMEOUTS_A_RST;
         cfg_ff.mbet_timeout_e    <= TIMEOUT_E_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/fdtu_engine.sv =====
// ----------------------------------------------------------------------------
// fdtu_engine
// sequencer and datapath: slot reduction, state read, gap and duration,
// products, ladder stepping, write-back and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "flow_dynamic_timeout_update_unit_assert.svh"

module fdtu_engine
   import fdtu_pkg::*;
#(
   parameter int FLOW_SLOTS = FLOW_SLOTS_DEF,
   parameter int MBET_STEPS = MBET_STEPS_DEF,
   localparam int AW = $clog2(FLOW_SLOTS)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  cfg_type            cfg,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_payload,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  flow_rec_type       mem_rd_data,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output flow_rec_type       mem_wr_data
);

   localparam int RECIP_SHIFT = 2 * SLOT_W;
   localparam int RECIP       = ((2 ** RECIP_SHIFT) + FLOW_SLOTS - 1) / FLOW_SLOTS;
   localparam int PROD_W      = SLOT_W + RECIP_SHIFT;
   localparam bit REDUCE      = FLOW_SLOTS < (2 ** SLOT_W);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MBET_STEPS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIFF,
      S_MUL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_payload_ff, rsp_payload_in;

   req_type              req_ff, req_in;
   logic [SLOT_W-1:0]    q_ff, q_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [55:0]          cnt_prod_ff, cnt_prod_in;
   logic [STAMP_W-1:0]   start_ff, start_in;
   logic                 gap_ok_ff, gap_ok_in;
   logic                 dur_neg_ff, dur_neg_in;
   logic [STAMP_W-1:0]   dur_ff, dur_in;
   logic [IDX_W-1:0]     mi_ff, mi_in;
   logic [IDX_W-1:0]     li_ff, li_in;
   logic [47:0]          dur_prod_ff, dur_prod_in;
   logic [IDX_W-1:0]     li_new_ff, li_new_in;

   logic               accept;
   logic               rsp_load;
   logic [PROD_W-1:0]  q_prod;
   logic [PROD_W-1:0]  qn;
   logic [PROD_W-1:0]  rem;
   logic [PROD_W-1:0]  rem_fix;
   logic [SLOT_W-1:0]  slot_red;
   logic [STAMP_W-1:0] start_v;
   logic [STAMP_W-1:0] prev_v;
   logic [STAMP_W:0]   gap_w;
   logic [STAMP_W:0]   dur_w;
   logic [IDX_W-1:0]   mi_new;
   logic [IDX_W-1:0]   li_new;
   logic               is_tcp;
   logic               is_udp;
   logic               tcp_now;
   logic [STAMP_W:0]   stamp_x;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // slot modulo depth by reciprocal multiply
   assign q_prod  = PROD_W'(req_payload.flow_slot) * PROD_W'(RECIP);
   assign qn      = PROD_W'(q_ff) * PROD_W'(FLOW_SLOTS);
   assign rem     = PROD_W'(req_ff.flow_slot) - qn;
   assign rem_fix = (rem >= PROD_W'(FLOW_SLOTS)) ? rem - PROD_W'(FLOW_SLOTS) : rem;
   assign slot_red = REDUCE ? SLOT_W'(rem_fix) : req_ff.flow_slot;

   // first packet seeds both times
   assign start_v = req_ff.first_packet ? req_ff.stamp_ms : mem_rd_data.flow_start;
   assign prev_v  = req_ff.first_packet ? req_ff.stamp_ms : mem_rd_data.prev_packet_time;
   assign gap_w   = {1'b0, req_ff.stamp_ms} - {1'b0, prev_v};
   assign dur_w   = {1'b0, req_ff.stamp_ms} - {1'b0, start_v};

   assign is_tcp  = (req_ff.protocol == PROTO_TCP);
   assign is_udp  = (req_ff.protocol == PROTO_UDP);
   assign stamp_x = {1'b0, req_ff.stamp_ms};

   // udp ladder stepping
   always_comb begin
      mi_new = mi_ff;
      li_new = li_ff;
      if (is_udp) begin
         if (req_ff.packet_count == COUNT_W'(1)) begin
            mi_new = IDX_W'(1);
            li_new = '0;
         end else if (req_ff.packet_count ==
                      COUNT_W'(mark_at(cfg.mbet_packet_marks, mi_ff, LAST_IDX))) begin
            if (mi_ff < LAST_IDX) begin
               mi_new = mi_ff + IDX_W'(1);
            end
            if (dur_neg_ff || (dur_ff < STAMP_W'(ladder_at(cfg.mbet_timeouts_a,
                                                        cfg.mbet_timeout_e,
                                                        li_ff, LAST_IDX)))) begin
               if (li_ff < LAST_IDX) begin
                  li_new = li_ff + IDX_W'(1);
               end
            end
         end
      end
   end

   assign tcp_now = gap_ok_ff
                    && (req_ff.packet_count <= COUNT_W'(cfg.short_packets))
                    && (dur_neg_ff || (56'(dur_prod_ff) <= cnt_prod_ff));

   always_comb begin
      req_in      = req_ff;
      q_in        = q_ff;
      slot_in     = slot_ff;
      cnt_prod_in = cnt_prod_ff;
      start_in    = start_ff;
      gap_ok_in   = gap_ok_ff;
      dur_neg_in  = dur_neg_ff;
      dur_in      = dur_ff;
      mi_in       = mi_ff;
      li_in       = li_ff;
      dur_prod_in = dur_prod_ff;
      li_new_in   = li_new_ff;

      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      mem_rd_en   = 1'b0;
      mem_rd_addr = AW'(slot_red);
      mem_wr_en   = 1'b0;
      mem_wr_addr = AW'(slot_ff);
      mem_wr_data.flow_start       = start_ff;
      mem_wr_data.prev_packet_time = req_ff.stamp_ms;
      mem_wr_data.mark_index       = mi_new;
      mem_wr_data.ladder_index     = li_new;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_payload;
               q_in     = q_prod[PROD_W-1:RECIP_SHIFT];
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_rd_en   = 1'b1;
            slot_in     = slot_red;
            cnt_prod_in = 56'(req_ff.packet_count) * 56'(cfg.short_gap);
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            start_in   = start_v;
            gap_ok_in  = !gap_w[STAMP_W] && (gap_w[STAMP_W-1:0] >= STAMP_W'(cfg.short_gap));
            dur_neg_in = dur_w[STAMP_W];
            dur_in     = dur_w[STAMP_W-1:0];
            mi_in      = clamp_idx(mem_rd_data.mark_index, LAST_IDX);
            li_in      = clamp_idx(mem_rd_data.ladder_index, LAST_IDX);
            state_in   = S_MUL;
         end
         S_MUL: begin
            mem_wr_en   = 1'b1;
            dur_prod_in = 48'(dur_ff) * 48'(cfg.short_packets);
            li_new_in   = li_new;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in           = 1'b1;
               rsp_payload_in.slot_out = slot_ff;
               if (is_tcp) begin
                  rsp_payload_in.expire_now = tcp_now;
                  rsp_payload_in.updated    = 1'b1;
                  rsp_payload_in.expire_ms  = tcp_now ? stamp_x
                                              : stamp_x + EXPIRE_W'(cfg.long_timeout);
               end else if (is_udp) begin
                  rsp_payload_in.expire_now = 1'b0;
                  rsp_payload_in.updated    = 1'b1;
                  rsp_payload_in.expire_ms  = stamp_x
                     + EXPIRE_W'(ladder_at(cfg.mbet_timeouts_a, cfg.mbet_timeout_e,
                                           li_new_ff, LAST_IDX));
               end else begin
                  rsp_payload_in.expire_now = 1'b0;
                  rsp_payload_in.updated    = 1'b0;
                  rsp_payload_in.expire_ms  = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      q_ff        <= q_in;
      slot_ff     <= slot_in;
      cnt_prod_ff <= cnt_prod_in;
      start_ff    <= start_in;
      gap_ok_ff   <= gap_ok_in;
      dur_neg_ff  <= dur_neg_in;
      dur_ff      <= dur_in;
      mi_ff       <= mi_in;
      li_ff       <= li_in;
      dur_prod_ff <= dur_prod_in;
      li_new_ff   <= li_new_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `FDTU_ASSERT_IMPL(a_no_rw_overlap, clock, reset, mem_rd_en, !mem_wr_en,
                     "state read and write-back in the same cycle")
   `FDTU_ASSERT_NEXT(a_read_follows_accept, clock, reset, accept, mem_rd_en,
                     "accepted beat not followed by a state read")
   `FDTU_ASSERT_IMPL(a_slot_in_range, clock, reset, mem_rd_en,
                     32'(slot_red) < 32'(FLOW_SLOTS),
                     "reduced slot beyond memory depth")
   `FDTU_ASSERT_IMPL(a_first_seeds_start, clock, reset,
                     mem_wr_en && req_ff.first_packet,
                     mem_wr_data.flow_start == req_ff.stamp_ms,
                     "first packet did not seed the flow start")

endmodule

`default_nettype wire

// ===== design/flow_dynamic_timeout_update_unit.sv =====
// ----------------------------------------------------------------------------
// flow_dynamic_timeout_update_unit
// per-flow expiry computation: short-flow test for tcp, step ladder for udp
// ----------------------------------------------------------------------------
// A packet beat runs through accept, slot reduction and state read, gap and
// duration, products and write-back, and result; the next beat is taken only
// after the result is loaded, which waits while the result side is stalled.
// The read-modify-write of the single-port-pair flow state memory keeps one
// beat in flight, so a packet always sees the state left by the one before
// it, also on the same flow. A finished result waits in the output register
// while the next beat is taken. Flow state is not cleared after reset: a slot
// must be opened by a first packet (and, for udp, see a packet count of one)
// before its stored times and ladder steps mean anything. Configuration
// writes take effect at once and are meant for an idle unit.
`timescale 1ns / 1ps
`default_nettype none

module flow_dynamic_timeout_update_unit
   import fdtu_pkg::*;
#(
   parameter int FLOW_SLOTS = FLOW_SLOTS_DEF,
   parameter int MBET_STEPS = MBET_STEPS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  req_type                     req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(FLOW_SLOTS);

   cfg_type      cfg;
   logic         mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   flow_rec_type mem_rd_data;
   logic         mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   flow_rec_type mem_wr_data;

   fdtu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fdtu_state_mem #(
      .FLOW_SLOTS (FLOW_SLOTS)
   ) u_state_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   fdtu_engine #(
      .FLOW_SLOTS (FLOW_SLOTS),
      .MBET_STEPS (MBET_STEPS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule

`default_nettype wire
